// ===== hw/rtl/mtp_pkg.sv =====
// Shared types, constants and helper functions for the move-to-pose drive controller.
// No dependencies; imported by the controller top level and its checker.
`default_nettype none

package mtp_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TARGET_X       = 3'd0;
  localparam logic [2:0] REG_TARGET_Y       = 3'd1;
  localparam logic [2:0] REG_TARGET_HEADING = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED      = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_MS     = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DRIVE   = 2'd0;
  localparam logic [1:0] ST_ARRIVED = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam int HALF_TURN    = 46080;
  localparam int FULL_TURN    = 92160;
  localparam int INV_GAIN_Q16 = 39797;
  localparam int RIGHT_ANGLE  = 90 * 65536;

  localparam int XW       = 44;  // CORDIC x/y width
  localparam int ZW       = 26;  // CORDIC angle width, 1/65536 degree
  localparam int DIV_BITS = 16;  // quotient bits of the scale divider

  // 1/5 as 0xCCCCCCCD / 2^34, exact for numerators below 2^32
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

  // per-item flags that ride along the front of the pipe
  typedef struct packed {
    logic                tmo;
    logic                zero;
    logic signed [18:0]  hd;
  } side_t;

  // scale divider stage contents
  typedef struct packed {
    logic [1:0]          st;
    logic                scale;
    logic signed [17:0]  l;
    logic signed [17:0]  r;
    logic [16:0]         d;
    logic [32:0]         nl;
    logic [32:0]         nr;
    logic [16:0]         rl;
    logic [16:0]         rr;
    logic [15:0]         ql;
    logic [15:0]         qr;
  } div_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117305;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // map an angle into [-180, 180) degrees; candidates are independent
  function automatic logic signed [16:0] wrap_angle(input logic signed [21:0] v);
    logic signed [31:0] r;
    logic signed [31:0] c;
    logic signed [16:0] res;
    r   = 32'(v) + HALF_TURN;
    res = '0;
    for (int k = -6; k <= 6; k++) begin
      c = r - k * FULL_TURN;
      if (c >= 0 && c < FULL_TURN) begin
        res = 17'(c - HALF_TURN);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/move_to_pose_drive_controller.sv =====
// Move-to-pose drive controller: pipelined CORDIC polar conversion, P control, mixing.
// Depends on mtp_pkg.
`default_nettype none

// channel   dir   handshake              payload
// in        in    in_valid / in_ready    pos_x, pos_y, heading, elapsed_ms
// out       out   out_valid / out_ready  left_power, right_power, status
// cfg       in    APB psel/penable       paddr, pwdata -> prdata
//
// One request enters per cycle unless stalled; the pipe has one CORDIC iteration per
// stage and one quotient bit per stage of the scale divider.
// The whole pipe advances when the output register is empty or being taken;
// in_ready follows that, so a stall holds every stage in place.
// rst clears valid bits and loads the register reset values.

module move_to_pose_drive_controller
  import mtp_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic signed [18:0] heading,
  input  wire logic [15:0]        elapsed_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      left_power,
  output logic signed [15:0]      right_power,
  output logic [1:0]              status,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // ---------------- configuration registers ----------------
  logic signed [23:0] target_x;
  logic signed [23:0] target_y;
  logic signed [18:0] target_heading;
  logic [14:0]        max_speed;
  logic [15:0]        timeout_ms;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x       <= '0;
      target_y       <= '0;
      target_heading <= '0;
      max_speed      <= 15'd25600;
      timeout_ms     <= 16'd2000;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_TARGET_X:       target_x       <= pwdata[23:0];
        REG_TARGET_Y:       target_y       <= pwdata[23:0];
        REG_TARGET_HEADING: target_heading <= pwdata[18:0];
        REG_MAX_SPEED:      max_speed      <= pwdata[14:0];
        REG_TIMEOUT_MS:     timeout_ms     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TARGET_X:       prdata = 32'(unsigned'(target_x));
      REG_TARGET_Y:       prdata = 32'(unsigned'(target_y));
      REG_TARGET_HEADING: prdata = 32'(unsigned'(target_heading));
      REG_MAX_SPEED:      prdata = 32'(max_speed);
      REG_TIMEOUT_MS:     prdata = 32'(timeout_ms);
      default:            prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic o_v;

  assign adv      = !o_v || out_ready;
  assign in_ready = adv;

  // ---------------- stage A: offsets and timeout ----------------
  logic               a_v;
  logic signed [24:0] a_dx;
  logic signed [24:0] a_dy;
  side_t              a_side;
  logic signed [24:0] dx_in;
  logic signed [24:0] dy_in;

  assign dx_in = 25'(target_x) - 25'(pos_x);
  assign dy_in = 25'(target_y) - 25'(pos_y);

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx        <= dx_in;
      a_dy        <= dy_in;
      a_side.tmo  <= elapsed_ms >= timeout_ms;
      a_side.zero <= (dx_in == '0) && (dy_in == '0);
      a_side.hd   <= heading;
    end
  end

  // ---------------- CORDIC: pre-rotation then one iteration per stage ----------------
  logic signed [XW-1:0] cx [0:CORDIC_STEPS];
  logic signed [XW-1:0] cy [0:CORDIC_STEPS];
  logic signed [ZW-1:0] cz [0:CORDIC_STEPS];
  side_t                cs [0:CORDIC_STEPS];
  logic                 cv [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= a_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs[0] <= a_side;
      if (!a_dx[24]) begin
        cx[0] <= XW'(a_dx) <<< 16;
        cy[0] <= XW'(a_dy) <<< 16;
        cz[0] <= '0;
      end else if (!a_dy[24]) begin
        cx[0] <= XW'(a_dy) <<< 16;
        cy[0] <= (-XW'(a_dx)) <<< 16;
        cz[0] <= ZW'(RIGHT_ANGLE);
      end else begin
        cx[0] <= (-XW'(a_dy)) <<< 16;
        cy[0] <= XW'(a_dx) <<< 16;
        cz[0] <= -ZW'(RIGHT_ANGLE);
      end
    end
  end

  for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_cordic
    localparam int SH = i - 1;
    always_ff @(posedge clk) begin
      if (rst) cv[i] <= 1'b0;
      else if (adv) cv[i] <= cv[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cs[i] <= cs[i-1];
        if (!cy[i-1][XW-1]) begin
          cx[i] <= cx[i-1] + (cy[i-1] >>> SH);
          cy[i] <= cy[i-1] - (cx[i-1] >>> SH);
          cz[i] <= cz[i-1] + atan_q16(SH);
        end else begin
          cx[i] <= cx[i-1] - (cy[i-1] >>> SH);
          cy[i] <= cy[i-1] + (cx[i-1] >>> SH);
          cz[i] <= cz[i-1] - atan_q16(SH);
        end
      end
    end
  end

  // ---------------- stage M1: gain correction partial products, bearing ----------------
  logic               m1_v;
  logic [37:0]        m1_lo;
  logic [36:0]        m1_hi;
  logic signed [17:0] m1_bear;
  side_t              m1_side;
  logic [42:0]        xpos;
  logic signed [ZW-1:0] zr;

  assign xpos = cx[CORDIC_STEPS][XW-1] ? '0 : cx[CORDIC_STEPS][42:0];
  assign zr   = cz[CORDIC_STEPS] + ZW'(128);

  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else if (adv) m1_v <= cv[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_lo   <= 38'(xpos[21:0]) * 38'(INV_GAIN_Q16);
      m1_hi   <= 37'(xpos[42:22]) * 37'(INV_GAIN_Q16);
      m1_bear <= 18'(zr >>> 8);
      m1_side <= cs[CORDIC_STEPS];
    end
  end

  // ---------------- stage M2: distance ----------------
  logic               m2_v;
  logic [25:0]        m2_dist;
  logic signed [17:0] m2_bear;
  side_t              m2_side;
  logic [59:0]        dsum;

  assign dsum = {1'b0, m1_hi, 22'b0} + 60'(m1_lo) + (60'd1 << 31);

  always_ff @(posedge clk) begin
    if (rst) m2_v <= 1'b0;
    else if (adv) m2_v <= m1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_dist <= m1_side.zero ? '0 : dsum[57:32];
      m2_bear <= m1_side.zero ? '0 : m1_bear;
      m2_side <= m1_side;
    end
  end

  // ---------------- stage W: angle errors, status, forward product ----------------
  logic               w_v;
  logic [1:0]         w_st;
  logic signed [16:0] w_eh;
  logic [59:0]        w_fprod;
  logic signed [16:0] eh_c;
  logic signed [16:0] et_c;
  logic               arrived;

  assign eh_c    = wrap_angle(22'(m2_bear) - 22'(m2_side.hd));
  assign et_c    = wrap_angle(22'(target_heading) - 22'(m2_side.hd));
  assign arrived = (m2_dist < 26'd256) && (et_c > -17'sd512) && (et_c < 17'sd512);

  always_ff @(posedge clk) begin
    if (rst) w_v <= 1'b0;
    else if (adv) w_v <= m2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_eh    <= eh_c;
      w_fprod <= 60'({m2_dist, 2'b10}) * 60'(RECIP5);
      if (m2_side.tmo) w_st <= ST_TIMEOUT;
      else if (arrived) w_st <= ST_ARRIVED;
      else w_st <= ST_DRIVE;
    end
  end

  // ---------------- stage F: clamp and mix ----------------
  logic               f_v;
  logic [1:0]         f_st;
  logic signed [17:0] f_l;
  logic signed [17:0] f_r;
  logic [25:0]        fq;
  logic signed [17:0] fwd_c;
  logic signed [17:0] turn_c;
  logic signed [17:0] twice_eh;
  logic signed [17:0] ms_s;

  assign fq       = w_fprod[59:34];
  assign ms_s     = 18'(max_speed);
  assign twice_eh = 18'(w_eh) <<< 1;
  assign fwd_c    = (fq > 26'(max_speed)) ? ms_s : 18'(fq);
  assign turn_c   = (twice_eh > ms_s) ? ms_s : ((twice_eh < -ms_s) ? -ms_s : twice_eh);

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= w_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_st <= w_st;
      f_l  <= fwd_c + turn_c;
      f_r  <= fwd_c - turn_c;
    end
  end

  // ---------------- stage G: magnitudes ----------------
  logic               g_v;
  logic [1:0]         g_st;
  logic signed [17:0] g_l;
  logic signed [17:0] g_r;
  logic [16:0]        g_al;
  logic [16:0]        g_ar;
  logic [16:0]        g_m;
  logic               g_scale;
  logic [16:0]        al_c;
  logic [16:0]        ar_c;
  logic [16:0]        m_c;

  assign al_c = f_l[17] ? 17'(-f_l) : 17'(f_l);
  assign ar_c = f_r[17] ? 17'(-f_r) : 17'(f_r);
  assign m_c  = (al_c > ar_c) ? al_c : ar_c;

  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (adv) g_v <= f_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_st    <= f_st;
      g_l     <= f_l;
      g_r     <= f_r;
      g_al    <= al_c;
      g_ar    <= ar_c;
      g_m     <= m_c;
      g_scale <= m_c > 17'(max_speed);
    end
  end

  // ---------------- stage H: divider operands, then one quotient bit per stage ----------------
  div_t dq [0:DIV_BITS];
  logic dv [0:DIV_BITS];
  logic [32:0] nl_c;
  logic [32:0] nr_c;

  assign nl_c = ((33'(g_al) * 33'(max_speed)) << 1) + 33'(g_m);
  assign nr_c = ((33'(g_ar) * 33'(max_speed)) << 1) + 33'(g_m);

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= g_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dq[0].st    <= g_st;
      dq[0].scale <= g_scale;
      dq[0].l     <= g_l;
      dq[0].r     <= g_r;
      dq[0].d     <= {g_m[15:0], 1'b0};
      dq[0].nl    <= nl_c;
      dq[0].nr    <= nr_c;
      dq[0].rl    <= nl_c[32:16];
      dq[0].rr    <= nr_c[32:16];
      dq[0].ql    <= '0;
      dq[0].qr    <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - k;
    logic [17:0] tl;
    logic [17:0] tr;
    div_t        nxt;

    assign tl = {dq[k-1].rl, dq[k-1].nl[B]};
    assign tr = {dq[k-1].rr, dq[k-1].nr[B]};

    always_comb begin
      nxt = dq[k-1];
      if (tl >= 18'(dq[k-1].d)) begin
        nxt.rl = 17'(tl - 18'(dq[k-1].d));
        nxt.ql = {dq[k-1].ql[14:0], 1'b1};
      end else begin
        nxt.rl = tl[16:0];
        nxt.ql = {dq[k-1].ql[14:0], 1'b0};
      end
      if (tr >= 18'(dq[k-1].d)) begin
        nxt.rr = 17'(tr - 18'(dq[k-1].d));
        nxt.qr = {dq[k-1].qr[14:0], 1'b1};
      end else begin
        nxt.rr = tr[16:0];
        nxt.qr = {dq[k-1].qr[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[k] <= 1'b0;
      else if (adv) dv[k] <= dv[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) dq[k] <= nxt;
    end
  end

  // ---------------- output register ----------------
  div_t               df;
  logic signed [15:0] lo_c;
  logic signed [15:0] ro_c;

  assign df = dq[DIV_BITS];

  always_comb begin
    if (df.st != ST_DRIVE) begin
      lo_c = '0;
      ro_c = '0;
    end else if (df.scale) begin
      lo_c = df.l[17] ? -signed'(df.ql) : signed'(df.ql);
      ro_c = df.r[17] ? -signed'(df.qr) : signed'(df.qr);
    end else begin
      lo_c = 16'(df.l);
      ro_c = 16'(df.r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) o_v <= 1'b0;
    else if (adv) o_v <= dv[DIV_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_power  <= lo_c;
      right_power <= ro_c;
      status      <= df.st;
    end
  end

  assign out_valid = o_v;

endmodule

`default_nettype wire

// ===== hw/rtl/mtp_checker.sv =====
// Port-level checks for the move-to-pose drive controller, bound to its top level.
// Depends on mtp_pkg and move_to_pose_drive_controller.
`default_nettype none

module mtp_sva
  import mtp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] left_power,
  input wire logic signed [15:0] right_power,
  input wire logic [1:0]         status
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_power) &&
    $stable(right_power) && $stable(status))
    else $error("result changed while stalled");

  // braking results carry zero power
  a_brake_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ARRIVED || status == ST_TIMEOUT) |->
    left_power == '0 && right_power == '0)
    else $error("brake result with nonzero power");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_DRIVE || status == ST_ARRIVED || status == ST_TIMEOUT)
    else $error("unknown status code");

  // an empty or draining output stage never blocks new requests
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

endmodule

bind move_to_pose_drive_controller mtp_sva u_mtp_sva (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .left_power  (left_power),
  .right_power (right_power),
  .status      (status)
);

`default_nettype wire
